// ----- sv/assert_macros.svh -----
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/rmrs_pkg.sv -----
package rmrs_pkg;

  // Value width of sums and multipliers
  localparam int VW = 30;

  localparam logic [VW-1:0] MODULUS = 30'd1000000007;
  localparam logic [VW-1:0] ONE     = 30'd1;

  // Default store size and reset element count
  localparam int LEAVES_DEF = 65536;
  localparam int N_RESET    = 65536;

  // Width of the element count register
  localparam int CFG_W = 17;

  // Modular add of two reduced values
  function automatic logic [VW-1:0] addmod(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODULUS}) begin
      s = s - {1'b0, MODULUS};
    end
    return s[VW-1:0];
  endfunction

endpackage

// ----- sv/rmrs_ram.sv -----
module rmrs_ram #(
  parameter int W     = 60,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // One write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/range_multiply_range_sum_tree.sv -----
// Range multiply / range sum store modulo 1000000007 over n_used elements, all one after
// reset and after every write of n_used. After reset and after each write of n_used the
// store is rebuilt by a sweep over every node of the tree (TL = LEAVES rounded up to a
// power of two) during which no transaction is taken. One item runs alone
// through a lazy segment tree held in a single RAM of {pending multiplier, sum}, with
// H = log2(TL) levels. The walk down the two boundary paths reads, per level and side, the
// boundary node where there is one and pushes a pending multiplier other than one to
// both children. The covering-node walk then sums each covering node, or scales its sum
// and pending multiplier by the bit-serial modular multiplier (two products per node).
// A multiply then rebuilds the boundary ancestors level by level, leaves first.
// An empty multiply goes straight back to idle; an empty sum returns zero.
// A sum result waits in an output register.
`include "assert_macros.svh"

module range_multiply_range_sum_tree #(
  parameter int LEAVES = rmrs_pkg::LEAVES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // item channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic [15:0]               left,
  input  logic [16:0]               right,
  input  logic [29:0]               factor,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [29:0]               range_sum,
  // register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int VW   = rmrs_pkg::VW;
  localparam int H    = $clog2(LEAVES);
  localparam int TL   = 1 << H;
  localparam int AW   = H + 1;
  localparam int LW2  = H + 2;
  localparam int NW   = $clog2(LEAVES + 1);
  localparam int CW   = (NW > rmrs_pkg::CFG_W) ? NW : rmrs_pkg::CFG_W;
  localparam int LVW  = $clog2(H + 1);
  localparam int NRST = (rmrs_pkg::N_RESET > LEAVES) ? LEAVES : rmrs_pkg::N_RESET;
  localparam int MCW  = $clog2(VW);

  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001,
    S_CLEAR = 22'h000002,
    S_PSEL  = 22'h000004,
    S_PRD   = 22'h000008,
    S_PWT   = 22'h000010,
    S_SRD   = 22'h000020,
    S_SWT   = 22'h000040,
    S_SMUL0 = 22'h000080,
    S_SMUL1 = 22'h000100,
    S_SWR   = 22'h000200,
    S_PWR   = 22'h000400,
    S_LOOPL = 22'h000800,
    S_LOOPR = 22'h001000,
    S_LSHF  = 22'h002000,
    S_ARD   = 22'h004000,
    S_AWT   = 22'h008000,
    S_USEL  = 22'h010000,
    S_URD0  = 22'h020000,
    S_URD1  = 22'h040000,
    S_UWT   = 22'h080000,
    S_UWR   = 22'h100000,
    S_OUT   = 22'h200000
  } state_t;

  state_t state;

  logic [NW-1:0]  n_used;
  logic [LW2-1:0] lo_leaf, hi_leaf, cl, cr;
  logic [LVW-1:0] lv;
  logic           side, is_sum, ch, push_mode, ret_right;
  logic [AW-1:0]  node, pnode;
  logic [VW-1:0]  f_in, f_scale, psum, sum_r, lazy_r, acc;
  logic [AW-1:0]  clr_node, clr_lo, clr_span;

  // shared modular multiplier
  logic [VW-1:0]  m_a, m_b, m_acc;
  logic [MCW-1:0] m_cnt;
  logic           m_busy, m_start;
  logic [VW-1:0]  m_opa;
  logic [VW:0]    m_t, m_t1, m_u, m_u1;

  // RAM ports
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [2*VW-1:0] wdata, rdata;
  logic [VW-1:0]   rd_sum, rd_lazy;

  // input decode
  logic [CW-1:0]  r_ext, n_ext, r_clamp;
  logic           empty;
  logic [VW-1:0]  f_red;

  // level walk select
  logic [LW2-1:0] lv_mask;
  logic           sel_hit;
  logic [AW-1:0]  sel_node;

  // clear sweep
  logic [AW-1:0]  clr_n, clr_diff, clr_cnt, clr_end;

  // register write decode
  logic           cfg_wr;
  logic [CW-1:0]  cfg_v;
  logic [NW-1:0]  n_next;

  assign pready   = 1'b1;
  assign prdata   = 32'(n_used);
  assign in_ready = (state == S_IDLE);
  assign cfg_wr   = psel && penable && pwrite && !paddr[2];

  assign rd_sum  = rdata[VW-1:0];
  assign rd_lazy = rdata[2*VW-1:VW];

  // Clamp and reduce the incoming transaction
  always_comb begin
    r_ext   = CW'(right);
    n_ext   = CW'(n_used);
    r_clamp = (r_ext > n_ext) ? n_ext : r_ext;
    empty   = CW'(left) >= r_clamp;
    f_red   = (factor >= rmrs_pkg::MODULUS) ? factor - rmrs_pkg::MODULUS : factor;
  end

  // Clamp a written element count into one .. LEAVES
  always_comb begin
    cfg_v = CW'(pwdata[rmrs_pkg::CFG_W-1:0]);
    if (cfg_v > CW'(LEAVES)) begin
      cfg_v = CW'(LEAVES);
    end
    if (cfg_v == '0) begin
      cfg_v = CW'(1);
    end
    n_next = NW'(cfg_v);
  end

  // Pick the boundary ancestor at level lv on the current side
  always_comb begin
    lv_mask = (LW2'(1) << lv) - LW2'(1);
    if (!side) begin
      sel_hit  = |(lo_leaf & lv_mask);
      sel_node = AW'(lo_leaf >> lv);
    end else begin
      sel_hit  = |(hi_leaf & lv_mask);
      sel_node = AW'((hi_leaf - LW2'(1)) >> lv);
    end
  end

  // Leaves in use under the node being cleared
  always_comb begin
    clr_n    = AW'(n_used);
    clr_diff = clr_n - clr_lo;
    clr_cnt  = (clr_n > clr_lo) ? ((clr_diff > clr_span) ? clr_span : clr_diff) : '0;
    clr_end  = clr_lo + clr_span;
  end

  // Multiplier step: double, then add the operand on a set bit
  always_comb begin
    m_t  = {m_acc, 1'b0};
    m_t1 = (m_t >= {1'b0, rmrs_pkg::MODULUS}) ? m_t - {1'b0, rmrs_pkg::MODULUS} : m_t;
    m_u  = m_t1 + (m_b[VW-1] ? {1'b0, m_a} : '0);
    m_u1 = (m_u >= {1'b0, rmrs_pkg::MODULUS}) ? m_u - {1'b0, rmrs_pkg::MODULUS} : m_u;
  end

  assign m_start = (state == S_SWT) || ((state == S_SMUL0) && !m_busy);
  assign m_opa   = (state == S_SWT) ? rd_sum : lazy_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_busy <= 1'b0;
    end else if (m_start) begin
      m_busy <= 1'b1;
      m_acc  <= '0;
      m_a    <= m_opa;
      m_b    <= f_scale;
      m_cnt  <= MCW'(VW - 1);
    end else if (m_busy) begin
      m_acc <= m_u1[VW-1:0];
      m_b   <= {m_b[VW-2:0], 1'b0};
      if (m_cnt == '0) begin
        m_busy <= 1'b0;
      end else begin
        m_cnt <= m_cnt - MCW'(1);
      end
    end
  end

  // RAM access per state
  always_comb begin
    we    = 1'b0;
    waddr = node;
    wdata = {lazy_r, sum_r};
    raddr = node;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_node;
        wdata = {rmrs_pkg::ONE, VW'(clr_cnt)};
      end
      S_SWR: begin
        we = 1'b1;
      end
      S_PWR: begin
        we    = 1'b1;
        waddr = pnode;
        wdata = {rmrs_pkg::ONE, psum};
      end
      S_UWR: begin
        we    = 1'b1;
        wdata = {rmrs_pkg::ONE, psum};
      end
      S_URD0: raddr = {node[AW-2:0], 1'b0};
      S_URD1: raddr = {node[AW-2:0], 1'b1};
      default: ;
    endcase
  end

  rmrs_ram #(
    .W     (2 * VW),
    .DEPTH (2 * TL)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      n_used    <= NW'(NRST);
      clr_node  <= AW'(1);
      clr_lo    <= '0;
      clr_span  <= AW'(TL);
      out_valid <= 1'b0;
    end else begin
      // drop a delivered result
      if (out_valid && out_ready && (state != S_OUT || cfg_wr)) begin
        out_valid <= 1'b0;
      end

      // a new element count restarts the rebuild
      if (cfg_wr) begin
        n_used   <= n_next;
        clr_node <= AW'(1);
        clr_lo   <= '0;
        clr_span <= AW'(TL);
        state    <= S_CLEAR;
      end else begin
        case (state)
          S_IDLE: begin
            if (in_valid) begin
              is_sum  <= op;
              f_in    <= f_red;
              lo_leaf <= LW2'(TL) + LW2'(left);
              hi_leaf <= LW2'(TL) + LW2'(r_clamp);
              cl      <= LW2'(TL) + LW2'(left);
              cr      <= LW2'(TL) + LW2'(r_clamp);
              lv      <= LVW'(H);
              side    <= 1'b0;
              acc     <= '0;
              if (empty) begin
                state <= op ? S_OUT : S_IDLE;
              end else begin
                state <= S_PSEL;
              end
            end
          end

          S_CLEAR: begin
            clr_node <= clr_node + AW'(1);
            if (clr_end == AW'(TL)) begin
              clr_lo   <= '0;
              clr_span <= clr_span >> 1;
            end else begin
              clr_lo <= clr_end;
            end
            if (clr_node == {AW{1'b1}}) begin
              state <= S_IDLE;
            end
          end

          // push pending multipliers down the two boundary paths, root first
          S_PSEL: begin
            if (sel_hit) begin
              node  <= sel_node;
              state <= S_PRD;
            end else begin
              side <= !side;
              if (side) begin
                if (lv == LVW'(1)) begin
                  state <= S_LOOPL;
                end else begin
                  lv <= lv - LVW'(1);
                end
              end
            end
          end

          S_PRD: state <= S_PWT;

          S_PWT: begin
            if (rd_lazy == rmrs_pkg::ONE) begin
              side  <= !side;
              state <= S_PSEL;
              if (side) begin
                if (lv == LVW'(1)) begin
                  state <= S_LOOPL;
                end else begin
                  lv <= lv - LVW'(1);
                end
              end
            end else begin
              f_scale   <= rd_lazy;
              psum      <= rd_sum;
              pnode     <= node;
              node      <= {node[AW-2:0], 1'b0};
              ch        <= 1'b0;
              push_mode <= 1'b1;
              state     <= S_SRD;
            end
          end

          // scale one node: sum and pending multiplier times f_scale
          S_SRD: state <= S_SWT;

          S_SWT: begin
            lazy_r <= rd_lazy;
            state  <= S_SMUL0;
          end

          S_SMUL0: begin
            if (!m_busy) begin
              sum_r <= m_acc;
              state <= S_SMUL1;
            end
          end

          S_SMUL1: begin
            if (!m_busy) begin
              lazy_r <= m_acc;
              state  <= S_SWR;
            end
          end

          S_SWR: begin
            if (push_mode) begin
              if (!ch) begin
                ch    <= 1'b1;
                node  <= {node[AW-1:1], 1'b1};
                state <= S_SRD;
              end else begin
                state <= S_PWR;
              end
            end else begin
              state <= ret_right ? S_LSHF : S_LOOPR;
            end
          end

          S_PWR: begin
            side  <= !side;
            state <= S_PSEL;
            if (side) begin
              if (lv == LVW'(1)) begin
                state <= S_LOOPL;
              end else begin
                lv <= lv - LVW'(1);
              end
            end
          end

          // bottom-up walk over the covering nodes
          S_LOOPL: begin
            if (cl < cr) begin
              if (cl[0]) begin
                node      <= AW'(cl);
                cl        <= cl + LW2'(1);
                ret_right <= 1'b0;
                push_mode <= 1'b0;
                f_scale   <= f_in;
                state     <= is_sum ? S_ARD : S_SRD;
              end else begin
                state <= S_LOOPR;
              end
            end else if (is_sum) begin
              state <= S_OUT;
            end else begin
              lv    <= LVW'(1);
              side  <= 1'b0;
              state <= S_USEL;
            end
          end

          S_LOOPR: begin
            if (cr[0]) begin
              node      <= AW'(cr - LW2'(1));
              cr        <= cr - LW2'(1);
              ret_right <= 1'b1;
              push_mode <= 1'b0;
              f_scale   <= f_in;
              state     <= is_sum ? S_ARD : S_SRD;
            end else begin
              state <= S_LSHF;
            end
          end

          S_LSHF: begin
            cl    <= cl >> 1;
            cr    <= cr >> 1;
            state <= S_LOOPL;
          end

          S_ARD: state <= S_AWT;

          S_AWT: begin
            acc   <= rmrs_pkg::addmod(acc, rd_sum);
            state <= ret_right ? S_LSHF : S_LOOPR;
          end

          // rebuild sums of the boundary ancestors, leaves first
          S_USEL: begin
            if (sel_hit) begin
              node  <= sel_node;
              state <= S_URD0;
            end else begin
              side <= !side;
              if (side) begin
                if (lv == LVW'(H)) begin
                  state <= S_IDLE;
                end else begin
                  lv <= lv + LVW'(1);
                end
              end
            end
          end

          S_URD0: state <= S_URD1;

          S_URD1: begin
            sum_r <= rd_sum;
            state <= S_UWT;
          end

          S_UWT: begin
            psum  <= rmrs_pkg::addmod(sum_r, rd_sum);
            state <= S_UWR;
          end

          S_UWR: begin
            side  <= !side;
            state <= S_USEL;
            if (side) begin
              if (lv == LVW'(H)) begin
                state <= S_IDLE;
              end else begin
                lv <= lv + LVW'(1);
              end
            end
          end

          // hold the result until the output register is free
          S_OUT: begin
            if (!out_valid || out_ready) begin
              out_valid <= 1'b1;
              range_sum <= acc;
              state     <= S_IDLE;
            end
          end

          default: state <= S_IDLE;
        endcase
      end
    end
  end

  `ASSERT_IMP(a_mul_free, clk, rst, m_start, !m_busy, "multiplier started while busy")
  `ASSERT_IMP(a_push_inner, clk, rst, state == S_PWT, node < AW'(TL), "push on a leaf")
  `ASSERT_IMP(a_sum_reduced, clk, rst, out_valid, range_sum < rmrs_pkg::MODULUS, "sum not reduced")
  `ASSERT_NXT(a_cfg_clear, clk, rst, cfg_wr, state == S_CLEAR, "rebuild not started")

endmodule

// ----- verif/tb_range_multiply_range_sum_tree.sv -----
module tb_range_multiply_range_sum_tree;

  localparam logic [2:0] ADDR_N_USED = 3'd0;
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_SUM = 1'b1;
  localparam int unsigned PRIME = 32'd1000000007;
  // cycles a multiply may still run after the last sum has come back
  localparam int SETTLE_CYCLES = 12000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic op;
  logic [15:0] left;
  logic [16:0] right;
  logic [29:0] factor;
  logic out_valid;
  logic out_ready;
  logic [29:0] range_sum;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // shadow of the stored values and the element count
  logic [29:0] elem_val [0:65535];
  int unsigned elem_count;
  logic [29:0] pending_sums [$];
  int fail_count;
  int in_idle_pct;
  int out_stall_pct;

  range_multiply_range_sum_tree uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .left(left), .right(right), .factor(factor),
    .out_valid(out_valid), .out_ready(out_ready), .range_sum(range_sum),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [29:0] mul_prime(input logic [29:0] a, input logic [29:0] b);
    longint unsigned p;
    p = longint'(a) * longint'(b);
    return 30'(p % PRIME);
  endfunction

  // set every element back to one for a new count
  task automatic refill_store(input logic [31:0] value);
    int unsigned v;
    v = value & 32'h1FFFF;
    if (v > 65536) v = 65536;
    if (v == 0) v = 1;
    elem_count = v;
    for (int i = 0; i < 65536; i++) elem_val[i] = 30'd1;
  endtask

  // apply one accepted transaction to the shadow store
  task automatic predict_item(input logic o, input logic [15:0] l, input logic [16:0] r,
                              input logic [29:0] f);
    int unsigned hi;
    logic [29:0] fr;
    longint unsigned acc;
    hi = (r > elem_count) ? elem_count : r;
    fr = 30'(f % PRIME);
    acc = 0;
    if (o == OP_MUL) begin
      for (int unsigned i = l; i < hi; i++) elem_val[i] = mul_prime(elem_val[i], fr);
    end else begin
      for (int unsigned i = l; i < hi; i++) acc = (acc + elem_val[i]) % PRIME;
      pending_sums.push_back(30'(acc));
    end
  endtask

  task automatic send_item(input logic o, input logic [15:0] l, input logic [16:0] r,
                           input logic [29:0] f);
    in_valid <= 1'b1;
    op <= o;
    left <= l;
    right <= r;
    factor <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(o, l, r, f);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // hold off the sender until nothing is outstanding and any multiply has finished
  task automatic drain_block;
    send_item(OP_SUM, 16'd0, 17'd0, 30'd0);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [31:0] value);
    drain_block();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_N_USED;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    refill_store(value);
  endtask

  // random transaction, mostly within the store, some with fully random fields
  task automatic send_random;
    logic o;
    logic [15:0] l;
    logic [16:0] r;
    logic [29:0] f;
    o = 1'($urandom_range(1));
    f = ($urandom_range(3) == 0) ? 30'($urandom_range(5)) : 30'($urandom);
    if ($urandom_range(9) == 0) begin
      l = 16'($urandom);
      r = 17'($urandom);
    end else begin
      l = 16'($urandom_range(elem_count + 2));
      r = 17'($urandom_range(elem_count + 3));
      if ($urandom_range(3) == 0 && r > l) r = l + 17'($urandom_range(3));
    end
    send_item(o, l, r, f);
  endtask

  task automatic test_reset_store;
    send_item(OP_SUM, 16'd0, 17'd65536, 30'd0);
    send_item(OP_SUM, 16'd0, 17'h1FFFF, 30'h3FFFFFFF);
    send_item(OP_SUM, 16'd500, 17'd500, 30'd0);
    send_item(OP_SUM, 16'hFFFF, 17'd3, 30'd0);
    send_item(OP_MUL, 16'd7, 17'd7, 30'd9);
    send_item(OP_MUL, 16'd0, 17'h1FFFF, 30'h3FFFFFFF);
    send_item(OP_SUM, 16'd0, 17'd65536, 30'd0);
    send_item(OP_MUL, 16'hFFFF, 17'd65536, 30'd1000000006);
    send_item(OP_SUM, 16'hFFFF, 17'd65536, 30'd0);
    send_item(OP_MUL, 16'd100, 17'd40000, 30'd0);
    send_item(OP_SUM, 16'd0, 17'd65536, 30'd0);
    send_item(OP_MUL, 16'hFFFF, 17'd0, 30'd1);
    send_item(OP_MUL, 16'd3, 17'd60000, 30'd123456789);
    send_item(OP_SUM, 16'd50, 17'd101, 30'd0);
    send_item(OP_SUM, 16'd40000, 17'd65535, 30'd5);
  endtask

  task automatic test_zero_count;
    write_count(32'd0);
    send_item(OP_SUM, 16'd0, 17'd1, 30'd0);
    send_item(OP_MUL, 16'd0, 17'd65536, 30'd1000000006);
    send_item(OP_SUM, 16'd0, 17'h1FFFF, 30'd0);
    send_item(OP_SUM, 16'd1, 17'd2, 30'd0);
    send_item(OP_MUL, 16'd0, 17'd1, 30'h3FFFFFFF);
    send_item(OP_SUM, 16'd0, 17'd1, 30'd0);
  endtask

  task automatic test_random_small;
    write_count(32'd37);
    in_idle_pct = 12; out_stall_pct = 50;
    repeat (200) send_random();
    drain_block();
    in_idle_pct = 50; out_stall_pct = 12;
    repeat (200) send_random();
    in_idle_pct = 0; out_stall_pct = 0;
    repeat (200) send_random();
  endtask

  task automatic test_oversize_count;
    write_count(32'h1FFFF);
    in_idle_pct = 12; out_stall_pct = 30;
    send_item(OP_MUL, 16'd0, 17'd65536, 30'd2);
    send_item(OP_SUM, 16'd0, 17'd65536, 30'd0);
    repeat (20) send_random();
  endtask

  // result side: compare each accepted sum, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_sums.size() == 0) begin
        $error("range_sum: unexpected result %0d", range_sum);
        fail_count++;
      end else if (range_sum !== pending_sums[0]) begin
        $error("range_sum: expected %0d actual %0d", pending_sums[0], range_sum);
        fail_count++;
        void'(pending_sums.pop_front());
      end else begin
        void'(pending_sums.pop_front());
      end
    end
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  initial begin
    #200000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    fail_count = 0;
    in_idle_pct = 12;
    out_stall_pct = 50;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_MUL;
    left = '0;
    right = '0;
    factor = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    refill_store(32'd65536);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_store();
    test_zero_count();
    test_random_small();
    test_oversize_count();
    drain_block();
    if (fail_count == 0 && pending_sums.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
